### sv/sps_pkg.sv
// sps_pkg: shared constants, command codes and control/status structs
// for the strided pattern search counter
// no dependencies
package sps_pkg;

	localparam int SPS_SOURCE_DEPTH  = 256;
	localparam int SPS_PATTERN_DEPTH = 16;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 9;

	localparam logic [1:0] CMD_SRC_WR = 2'd0;
	localparam logic [1:0] CMD_PAT_WR = 2'd1;
	localparam logic [1:0] CMD_SEARCH = 2'd2;

	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_START    = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_RANGE_END      = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_STRIDE         = 2'd3;

	typedef struct packed {
		logic src_we;
		logic pat_we;
		logic init;
		logic set_err;
		logic clear_k;
		logic inc_k;
		logic step_pos;
		logic record_match;
		logic load_out;
	} sps_cmd_t;

	typedef struct packed {
		logic range_bad;
		logic fits;
		logic byte_eq;
		logic last_k;
	} sps_sts_t;

endpackage

### sv/strided_pattern_search_count_top.sv
// strided_pattern_search_count_top: strided pattern search with match count
// depends on sps_pkg, sps_ctrl, sps_datapath
//
// Write beats (source or pattern byte) give no result; an unknown command is taken and dropped.
// A search beat holds off input until its result is loaded into the output register: setup
// checks the range, then each candidate window is checked to fit, and each pattern byte compared
// takes a read state and a compare state (the compare stops at the first mismatching byte);
// once no window fits, the result is loaded. The read state is needed for the registered reads
// of the source and pattern memories. A bad range goes straight to loading the result.
// New beats are taken while a result still waits on the output side; only the next search waits.
// The memories are not cleared at reset and must be written before they are searched.
module strided_pattern_search_count_top import sps_pkg::*; #(
	parameter int SOURCE_DEPTH  = SPS_SOURCE_DEPTH,
	parameter int PATTERN_DEPTH = SPS_PATTERN_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             cmd,
	input  logic [7:0]             addr,
	input  logic [7:0]             data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   found,
	output logic [7:0]             first_position,
	output logic [8:0]             match_count,
	output logic                   range_error
);

	sps_cmd_t ctl;
	sps_sts_t sts;

	sps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	sps_datapath #(
		.SOURCE_DEPTH  (SOURCE_DEPTH),
		.PATTERN_DEPTH (PATTERN_DEPTH)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.addr           (addr),
		.data           (data),
		.ctl            (ctl),
		.sts            (sts),
		.found          (found),
		.first_position (first_position),
		.match_count    (match_count),
		.range_error    (range_error)
	);

endmodule

### sv/sps_datapath.sv
// sps_datapath: config registers, source and pattern memories, scan position,
// byte compare and result registers
// depends on sps_pkg
module sps_datapath import sps_pkg::*; #(
	parameter int SOURCE_DEPTH  = SPS_SOURCE_DEPTH,
	parameter int PATTERN_DEPTH = SPS_PATTERN_DEPTH
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic [7:0]             addr,
	input  logic [7:0]             data,
	input  sps_cmd_t               ctl,
	output sps_sts_t               sts,
	output logic                   found,
	output logic [7:0]             first_position,
	output logic [8:0]             match_count,
	output logic                   range_error
);

	localparam int SA_W  = (SOURCE_DEPTH > 1) ? $clog2(SOURCE_DEPTH) : 1;
	localparam int PA_W  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
	localparam int POS_W = $clog2(SOURCE_DEPTH + 512);

	logic [7:0] range_start_q;
	logic [8:0] range_end_q;
	logic [4:0] pattern_length_q;
	logic [7:0] stride_q;

	logic [7:0] src_mem [SOURCE_DEPTH];
	logic [7:0] pat_mem [PATTERN_DEPTH];
	logic [7:0] src_rd_q;
	logic [7:0] pat_rd_q;

	logic [SA_W-1:0] src_wmap [256];
	logic [PA_W-1:0] pat_wmap [256];
	logic [SA_W-1:0] src_raddr;
	logic [PA_W-1:0] pat_raddr;

	logic [POS_W-1:0] pos_q;
	logic [4:0]       k_q;
	logic             found_q;
	logic [7:0]       first_q;
	logic [8:0]       count_q;
	logic             err_q;

	logic             found_out_q;
	logic [7:0]       first_out_q;
	logic [8:0]       count_out_q;
	logic             err_out_q;

	logic [POS_W-1:0] end_eff;
	logic [POS_W-1:0] start_ext;
	logic [POS_W-1:0] len_ext;
	logic [POS_W-1:0] step_ext;

	// write address folding tables
	for (genvar gi = 0; gi < 256; gi++) begin : g_wmap
		localparam int SRC_IDX = gi % SOURCE_DEPTH;
		localparam int PAT_IDX = gi % PATTERN_DEPTH;
		assign src_wmap[gi] = SA_W'(SRC_IDX);
		assign pat_wmap[gi] = PA_W'(PAT_IDX);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_start_q    <= 8'd0;
			range_end_q      <= 9'd256;
			pattern_length_q <= 5'd1;
			stride_q         <= 8'd1;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RANGE_START:    range_start_q    <= cfg_data[7:0];
				REG_RANGE_END:      range_end_q      <= cfg_data[8:0];
				REG_PATTERN_LENGTH: pattern_length_q <= cfg_data[4:0];
				REG_STRIDE:         stride_q         <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

	assign src_raddr = SA_W'(pos_q + POS_W'(k_q));
	assign pat_raddr = PA_W'(k_q);

	always_ff @(posedge clk) begin
		if (ctl.src_we) begin
			src_mem[src_wmap[addr]] <= data;
		end
		src_rd_q <= src_mem[src_raddr];
	end

	always_ff @(posedge clk) begin
		if (ctl.pat_we) begin
			pat_mem[pat_wmap[addr]] <= data;
		end
		pat_rd_q <= pat_mem[pat_raddr];
	end

	always_comb begin
		if (POS_W'(range_end_q) > POS_W'(SOURCE_DEPTH)) begin
			end_eff = POS_W'(SOURCE_DEPTH);
		end else begin
			end_eff = POS_W'(range_end_q);
		end
	end

	assign start_ext = POS_W'(range_start_q);
	assign len_ext   = POS_W'(pattern_length_q);
	assign step_ext  = (stride_q == 8'd0) ? POS_W'(1) : POS_W'(stride_q);

	assign sts.range_bad = (start_ext >= end_eff) || (pattern_length_q == 5'd0) ||
		(len_ext > POS_W'(PATTERN_DEPTH)) || (len_ext > end_eff - start_ext);
	assign sts.fits    = (pos_q + len_ext) <= end_eff;
	assign sts.byte_eq = src_rd_q == pat_rd_q;
	assign sts.last_k  = k_q == (pattern_length_q - 5'd1);

	// scan state and running result
	always_ff @(posedge clk) begin
		if (ctl.init) begin
			pos_q   <= start_ext;
			found_q <= 1'b0;
			first_q <= 8'd0;
			count_q <= 9'd0;
			err_q   <= 1'b0;
		end else begin
			if (ctl.set_err) begin
				err_q <= 1'b1;
			end
			if (ctl.step_pos) begin
				pos_q <= pos_q + step_ext;
			end
			if (ctl.record_match) begin
				if (!found_q) begin
					first_q <= pos_q[7:0];
				end
				found_q <= 1'b1;
				if (count_q != 9'd511) begin
					count_q <= count_q + 9'd1;
				end
			end
		end
		if (ctl.clear_k) begin
			k_q <= 5'd0;
		end else if (ctl.inc_k) begin
			k_q <= k_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			found_out_q <= found_q;
			first_out_q <= first_q;
			count_out_q <= count_q;
			err_out_q   <= err_q;
		end
	end

	assign found          = found_out_q;
	assign first_position = first_out_q;
	assign match_count    = count_out_q;
	assign range_error    = err_out_q;

endmodule

### sv/sps_ctrl.sv
// sps_ctrl: controller state machine for loads and the search scan,
// plus output beat valid
// depends on sps_pkg
module sps_ctrl import sps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] cmd,
	output logic       out_valid,
	input  logic       out_ready,
	input  sps_sts_t   sts,
	output sps_cmd_t   ctl
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_CHECK = 6'b000010,
		ST_WIN   = 6'b000100,
		ST_READ  = 6'b001000,
		ST_CMP   = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;

	assign in_ready = state_q == ST_IDLE;
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (cmd)
						CMD_SRC_WR: ctl.src_we = 1'b1;
						CMD_PAT_WR: ctl.pat_we = 1'b1;
						CMD_SEARCH: begin
							ctl.init = 1'b1;
							state_d  = ST_CHECK;
						end
						default: begin
						end
					endcase
				end
			end
			ST_CHECK: begin
				if (sts.range_bad) begin
					ctl.set_err = 1'b1;
					state_d     = ST_DONE;
				end else begin
					state_d = ST_WIN;
				end
			end
			ST_WIN: begin
				if (sts.fits) begin
					ctl.clear_k = 1'b1;
					state_d     = ST_READ;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_READ: begin
				state_d = ST_CMP;
			end
			ST_CMP: begin
				if (!sts.byte_eq) begin
					ctl.step_pos = 1'b1;
					state_d      = ST_WIN;
				end else if (sts.last_k) begin
					ctl.record_match = 1'b1;
					ctl.step_pos     = 1'b1;
					state_d          = ST_WIN;
				end else begin
					ctl.inc_k = 1'b1;
					state_d   = ST_READ;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					ctl.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	a_cmp_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) |-> ($past(state_q) == ST_READ))
		else $error("compare without a preceding read");

	a_search_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd == CMD_SEARCH) |=> (state_q == ST_CHECK))
		else $error("search beat did not start a scan");

	a_bad_range_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK && sts.range_bad) |=> (state_q == ST_DONE))
		else $error("bad range did not end the search");

	a_result_issued: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && (!out_valid_q || out_ready)) |=>
		(out_valid_q && state_q == ST_IDLE))
		else $error("finished search gave no result beat");

endmodule

### test/tb_strided_pattern_search_count_top.sv
// tb_strided_pattern_search_count_top: self-checking bench for the strided pattern search
// depends on sps_pkg and strided_pattern_search_count_top; predicts every search result
// from shadow copies of both stores and the config registers, checks each result beat in order
`timescale 1ns / 100ps

module tb_strided_pattern_search_count_top import sps_pkg::*;;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] addr;
		logic [7:0] data;
	} op_t;

	typedef struct packed {
		logic       found;
		logic [7:0] first_position;
		logic [8:0] match_count;
		logic       range_error;
	} match_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic [1:0]             cmd = '0;
	logic [7:0]             addr = '0;
	logic [7:0]             data = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   found;
	logic [7:0]             first_position;
	logic [8:0]             match_count;
	logic                   range_error;

	// shadow state of the block
	logic [7:0] src_img [SPS_SOURCE_DEPTH];
	logic [7:0] pat_img [SPS_PATTERN_DEPTH];
	logic [7:0] pat_plan [SPS_PATTERN_DEPTH];
	logic [7:0] cfg_start = 8'd0;
	logic [8:0] cfg_end = 9'd256;
	logic [4:0] cfg_len = 5'd1;
	logic [7:0] cfg_stride = 8'd1;

	op_t    cmd_queue [$];
	match_t awaited [$];
	op_t    cur_op;
	bit     beat_taken = 1'b0;
	bit     idle_en = 1'b1;
	int     send_gap = 0;
	int     rx_gap = 0;
	int     rx_hold = 0;
	int     pushed = 0;
	int     err_count = 0;

	strided_pattern_search_count_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.addr(addr),
		.data(data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.first_position(first_position),
		.match_count(match_count),
		.range_error(range_error)
	);

	always #1 clk = ~clk;

	task automatic report_error(input string msg);
		err_count++;
		if (err_count <= 40) $display("mismatch at %0t: %s", $time, msg);
	endtask

	function automatic match_t scan_source();
		match_t      r;
		int unsigned lo, lim, n, step, pos, k, hits;
		bit          ok;
		r = '0;
		lo = cfg_start;
		n = cfg_len;
		lim = (cfg_end > SPS_SOURCE_DEPTH) ? SPS_SOURCE_DEPTH : cfg_end;
		step = (cfg_stride == 0) ? 1 : cfg_stride;
		if (lo >= lim || n == 0 || n > SPS_PATTERN_DEPTH || n > lim - lo) begin
			r.range_error = 1'b1;
			return r;
		end
		hits = 0;
		for (pos = lo; pos + n <= lim; pos += step) begin
			ok = 1'b1;
			for (k = 0; k < n; k++)
				if (src_img[(pos + k) % SPS_SOURCE_DEPTH] != pat_img[k]) ok = 1'b0;
			if (ok) begin
				if (hits == 0) begin
					r.found = 1'b1;
					r.first_position = pos[7:0];
				end
				if (hits < 511) hits++;
			end
		end
		r.match_count = hits[8:0];
		return r;
	endfunction

	task automatic apply_op(input op_t op);
		case (op.cmd)
			CMD_SRC_WR: src_img[op.addr % SPS_SOURCE_DEPTH] = op.data;
			CMD_PAT_WR: pat_img[op.addr % SPS_PATTERN_DEPTH] = op.data;
			CMD_SEARCH: awaited.push_back(scan_source());
			default: ;
		endcase
	endtask

	task automatic check_result();
		match_t want;
		if (awaited.size() == 0) begin
			report_error("result beat with nothing expected");
			return;
		end
		want = awaited.pop_front();
		if (found !== want.found)
			report_error($sformatf("found %0b, expected %0b", found, want.found));
		if (first_position !== want.first_position)
			report_error($sformatf("first_position %0d, expected %0d",
				first_position, want.first_position));
		if (match_count !== want.match_count)
			report_error($sformatf("match_count %0d, expected %0d",
				match_count, want.match_count));
		if (range_error !== want.range_error)
			report_error($sformatf("range_error %0b, expected %0b",
				range_error, want.range_error));
	endtask

	// accept and check at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				beat_taken = 1'b1;
				apply_op(cur_op);
			end
			if (out_valid && out_ready) check_result();
		end
	end

	// driver
	always @(negedge clk) begin
		if (arst_n && (beat_taken || !in_valid)) begin
			beat_taken = 1'b0;
			if (send_gap != 0) begin
				send_gap--;
				in_valid <= 1'b0;
			end else if (idle_en && cmd_queue.size() != 0 && $urandom_range(0, 11) == 0) begin
				send_gap = $urandom_range(0, 14);
				in_valid <= 1'b0;
			end else if (cmd_queue.size() != 0) begin
				cur_op = cmd_queue.pop_front();
				in_valid <= 1'b1;
				cmd <= cur_op.cmd;
				addr <= cur_op.addr;
				data <= cur_op.data;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_hold != 0) begin
				rx_hold--;
				out_ready <= 1'b0;
			end else if (rx_gap != 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else if (idle_en && $urandom_range(0, 9) == 0) begin
				rx_gap = $urandom_range(0, 14);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(0, 3))
			0: return 8'($urandom_range(0, 255));
			1: return 8'h3C;
			default: return 8'hC3;
		endcase
	endfunction

	function automatic void push_op(input logic [1:0] c, input logic [7:0] a,
		input logic [7:0] d);
		cmd_queue.push_back('{c, a, d});
		if (c == CMD_PAT_WR) pat_plan[a % SPS_PATTERN_DEPTH] = d;
		pushed++;
	endfunction

	// copy the pattern into the source at the given window of the current range
	function automatic void plant_copy(input int unsigned widx);
		int unsigned lim, step, pos, k;
		lim = (cfg_end > SPS_SOURCE_DEPTH) ? SPS_SOURCE_DEPTH : cfg_end;
		step = (cfg_stride == 0) ? 1 : cfg_stride;
		pos = cfg_start + step * widx;
		if (cfg_len == 0 || cfg_len > SPS_PATTERN_DEPTH || pos + cfg_len > lim) return;
		for (k = 0; k < cfg_len; k++)
			push_op(CMD_SRC_WR, 8'(pos + k), pat_plan[k]);
	endfunction

	task automatic wait_drained();
		while (cmd_queue.size() != 0 || in_valid || awaited.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[8:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_RANGE_START:    cfg_start = val[7:0];
			REG_RANGE_END:      cfg_end = val[8:0];
			REG_PATTERN_LENGTH: cfg_len = val[4:0];
			REG_STRIDE:         cfg_stride = val[7:0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int unsigned s, input int unsigned e,
		input int unsigned l, input int unsigned st);
		wait_drained();
		write_reg(REG_RANGE_START, s);
		write_reg(REG_RANGE_END, e);
		write_reg(REG_PATTERN_LENGTH, l);
		write_reg(REG_STRIDE, st);
	endtask

	initial begin
		int unsigned s, e, l, st, n, i, sel;
		int          phase;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// fill both stores so no search reads an unwritten byte
		for (i = 0; i < SPS_SOURCE_DEPTH; i++) push_op(CMD_SRC_WR, 8'(i), rand_byte());
		for (i = 0; i < SPS_PATTERN_DEPTH; i++) push_op(CMD_PAT_WR, 8'(i), rand_byte());
		wait_drained();

		// directed: reset settings, top addresses, dropped command
		push_op(CMD_UNUSED, 8'hFF, 8'hFF);
		push_op(CMD_PAT_WR, 8'hFF, 8'h00);
		push_op(CMD_SRC_WR, 8'hFF, 8'hFF);
		push_op(CMD_SEARCH, 8'h00, 8'h00);
		// single window at the last position
		set_config(255, 256, 1, 255);
		plant_copy(0);
		push_op(CMD_SEARCH, 8'h00, 8'h00);
		// zero stride, match at position zero
		set_config(0, 20, 2, 0);
		plant_copy(0);
		plant_copy(3);
		push_op(CMD_SEARCH, 8'h00, 8'h00);
		// end beyond the store, longest pattern
		set_config(0, 511, 16, 1);
		push_op(CMD_SEARCH, 8'h00, 8'h00);
		// invalid ranges, then the smallest valid range
		set_config(10, 10, 1, 1);
		push_op(CMD_SEARCH, 8'h00, 8'h00);
		set_config(200, 100, 1, 1);
		push_op(CMD_SEARCH, 8'h00, 8'h00);
		set_config(0, 256, 0, 1);
		push_op(CMD_SEARCH, 8'h00, 8'h00);
		set_config(0, 256, 17, 1);
		push_op(CMD_SEARCH, 8'h00, 8'h00);
		set_config(5, 0, 31, 3);
		push_op(CMD_SEARCH, 8'h00, 8'h00);
		set_config(250, 256, 7, 1);
		push_op(CMD_SEARCH, 8'h00, 8'h00);
		set_config(0, 1, 1, 1);
		push_op(CMD_SEARCH, 8'h00, 8'h00);

		phase = 0;
		while (pushed < 950) begin
			if (pushed > 850) idle_en = 1'b0;
			s = ($urandom_range(0, 9) == 0) ? 255 : $urandom_range(0, 220);
			case ($urandom_range(0, 9))
				0: e = 256;
				1: e = $urandom_range(257, 511);
				2: e = $urandom_range(s, 0);
				default: e = s + $urandom_range(1, 60);
			endcase
			sel = $urandom_range(0, 9);
			if (sel < 8) l = $urandom_range(1, 4);
			else if (sel == 8) l = $urandom_range(5, 16);
			else l = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(17, 31);
			st = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 4) : $urandom_range(1, 255);
			set_config(s, e, l, st);
			if (phase == 2) begin
				@(posedge clk);
				rx_hold = 600;
			end
			n = (phase == 2) ? 60 : $urandom_range(10, 40);
			for (i = 0; i < n; i++) begin
				if (phase == 5 && i == n / 2) wait_drained();
				sel = $urandom_range(0, 99);
				if (sel < 30)
					push_op(CMD_SRC_WR, 8'($urandom_range(0, 255)), rand_byte());
				else if (sel < 40)
					push_op(CMD_PAT_WR, 8'($urandom_range(0, 255)), rand_byte());
				else if (sel < 45)
					push_op(CMD_UNUSED, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				else if (sel < 60)
					plant_copy($urandom_range(0, 7));
				else
					push_op(CMD_SEARCH, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
			end
			phase++;
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (err_count == 0)
			$display("tb_strided_pattern_search_count_top: done, clean");
		else
			$display("tb_strided_pattern_search_count_top: done, errors");
		$finish;
	end

	initial begin
		#40000000;
		$display("tb_strided_pattern_search_count_top: done, errors");
		$finish;
	end

endmodule
